[rtl/swmf_pkg.sv]
// Shared definitions for the sliding window median filter.
// Holds parameter defaults and the controller-to-datapath command bundle.
// No dependencies.
package swmf_pkg;

  localparam int WINDOW_DEFAULT      = 9;
  localparam int SAMPLE_BITS_DEFAULT = 16;

  typedef struct packed {
    logic load;   // write the sample into the ring and snapshot the ring
    logic sort;   // run one odd-even transposition pass
    logic odd;    // pass parity: compare pairs starting at odd positions
    logic emit;   // copy the middle element into the output register
  } cmd_t;

endpackage

[rtl/swmf_ctrl.sv]
// Sequencer of the sliding window median filter: handshakes and sort passes.
// Depends on swmf_pkg (cmd_t).
module swmf_ctrl #(
  parameter int WINDOW = swmf_pkg::WINDOW_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  logic           m_tready,
  output swmf_pkg::cmd_t cmd
);

  localparam int PASS_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SORT = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]           state;
  logic [1:0]           state_next;
  logic [PASS_BITS-1:0] pass;
  logic [PASS_BITS-1:0] pass_next;
  logic                 out_valid;
  logic                 last_pass;

  assign last_pass = (pass == PASS_BITS'(WINDOW - 1));
  assign s_tready  = (state == ST_IDLE);
  assign m_tvalid  = out_valid;

  always_comb begin
    state_next = state;
    pass_next  = pass;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          pass_next  = '0;
          state_next = ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort = 1'b1;
        cmd.odd  = pass[0];
        if (last_pass) begin
          state_next = ST_DONE;
        end else begin
          pass_next = pass + 1'b1;
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid || m_tready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pass      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      pass  <= pass_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

[rtl/swmf_datapath.sv]
// Datapath of the sliding window median filter: sample ring, sort array,
// compare-exchange row and output register. Depends on swmf_pkg (cmd_t).
module swmf_datapath #(
  parameter int WINDOW      = swmf_pkg::WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  swmf_pkg::cmd_t         cmd,
  input  logic [SAMPLE_BITS-1:0] sample,
  output logic [SAMPLE_BITS-1:0] median
);

  localparam int IDX_BITS = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic signed [SAMPLE_BITS-1:0] ring [WINDOW];
  logic signed [SAMPLE_BITS-1:0] work [WINDOW];
  logic signed [SAMPLE_BITS-1:0] work_next [WINDOW];
  logic [IDX_BITS-1:0]           wpos;
  logic [SAMPLE_BITS-1:0]        median_reg;

  assign median = median_reg;

  // one transposition pass: disjoint adjacent pairs swap when out of order
  always_comb begin
    work_next = work;
    for (int i = 0; i < WINDOW - 1; i++) begin
      if ((((i & 1) == 1) == cmd.odd) && (work[i] > work[i+1])) begin
        work_next[i]   = work[i+1];
        work_next[i+1] = work[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW; i++) begin
        ring[i] <= '0;
      end
      wpos <= '0;
    end else if (cmd.load) begin
      ring[wpos] <= $signed(sample);
      wpos       <= (wpos == IDX_BITS'(WINDOW - 1)) ? '0 : wpos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // snapshot the ring with the new sample already in place
      for (int i = 0; i < WINDOW; i++) begin
        work[i] <= (IDX_BITS'(i) == wpos) ? $signed(sample) : ring[i];
      end
    end else if (cmd.sort) begin
      work <= work_next;
    end
    if (cmd.emit) begin
      median_reg <= work[WINDOW/2];
    end
  end

endmodule

[rtl/sliding_window_median_filter.sv]
// Sliding window median filter top level: stream ports, controller and datapath.
// Depends on swmf_pkg, swmf_ctrl and swmf_datapath.
//
// Usage:
//   Input channel s_*: one signed sample per beat in the low SAMPLE_BITS bits of
//   s_tdata. Output channel m_*: one median per input beat, in the same place.
//   Each accepted sample overwrites the oldest ring entry; the result is the
//   element at position WINDOW/2 of the sorted ring.
//   Sequence: a sample is loaded, then sorted by WINDOW odd-even transposition
//   passes over a register row, then the middle element is moved into the
//   output register; the same register write sets m_tvalid. s_tready is high
//   only while no sample is being sorted, so a new beat is taken only after the
//   previous median has been moved to the output register.
//   The next sample is accepted while an earlier median still waits in the
//   output register. If the receiver stalls longer, the finished median is held
//   inside and s_tready stays low until the output register frees up.
//   Reset (rst, synchronous) zeroes the ring and write position and drops any
//   pending result, so the first WINDOW-1 medians include those zeros.
module sliding_window_median_filter #(
  parameter int WINDOW      = swmf_pkg::WINDOW_DEFAULT,
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [((SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,   // [SAMPLE_BITS-1:0] sample
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [((SAMPLE_BITS+7)/8)*8-1:0]    m_tdata    // [SAMPLE_BITS-1:0] median
);

  localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  swmf_pkg::cmd_t         cmd;
  logic [SAMPLE_BITS-1:0] median;

  swmf_ctrl #(
    .WINDOW(WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  swmf_datapath #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .sample (s_tdata[SAMPLE_BITS-1:0]),
    .median (median)
  );

  assign m_tdata = DATA_BITS'(median);

endmodule

[rtl/swmf_checker.sv]
// Port-level checks for the sliding window median filter, bound to the top.
// Depends on swmf_pkg and the sliding_window_median_filter port names.
module swmf_checker #(
  parameter int SAMPLE_BITS = swmf_pkg::SAMPLE_BITS_DEFAULT
) (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic [((SAMPLE_BITS+7)/8)*8-1:0] m_tdata
);

  // stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled median beat changed or dropped");

  // no result pending after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("median valid right after reset");

  // one sample in flight: busy after an input beat
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while a sample is still sorting");

  // a median never shows up the cycle after its sample
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !$rose(m_tvalid))
    else $error("median appeared before the sort finished");

  // a fresh result frees the input side
  assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> s_tready)
    else $error("input still blocked after a median was delivered");

endmodule

bind sliding_window_median_filter swmf_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_swmf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

[verif/sliding_window_median_filter_test.sv]
// Self-checking testbench for sliding_window_median_filter: streams signed samples in,
// predicts each running median from its own copy of the ring, and checks every beat out.
// Depends on swmf_pkg and the sliding_window_median_filter RTL.
module sliding_window_median_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN        = swmf_pkg::WINDOW_DEFAULT;
  localparam int SB         = swmf_pkg::SAMPLE_BITS_DEFAULT;
  localparam int DW         = ((SB + 7) / 8) * 8;
  localparam int MAX_GAP    = 17;
  localparam int HOLD_LEN   = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int N_RANDOM   = 880;

  typedef logic signed [SB-1:0] sample_t;

  // Keeps a shadow of the ring and the medians still owed by the block.
  class median_scoreboard;
    sample_t ring [WIN];
    int      wr_pos;
    sample_t expected_medians [$];
    int      errors;
    int      checked;

    function new();
      foreach (ring[i]) ring[i] = '0;
      wr_pos  = 0;
      errors  = 0;
      checked = 0;
    endfunction

    function sample_t ring_median();
      sample_t sorted [WIN];
      sample_t key;
      int      j;
      sorted = ring;
      for (int i = 1; i < WIN; i++) begin
        key = sorted[i];
        j   = i - 1;
        while (j >= 0 && sorted[j] > key) begin
          sorted[j+1] = sorted[j];
          j--;
        end
        sorted[j+1] = key;
      end
      return sorted[WIN/2];
    endfunction

    function void note_sample(sample_t s);
      ring[wr_pos] = s;
      wr_pos = (wr_pos == WIN - 1) ? 0 : wr_pos + 1;
      expected_medians.push_back(ring_median());
    endfunction

    function void check_median(sample_t got);
      sample_t want;
      checked++;
      if (expected_medians.size() == 0) begin
        $display("%0t: median %0d arrived with nothing expected", $time, got);
        errors++;
        return;
      end
      want = expected_medians.pop_front();
      if (got !== want) begin
        $display("%0t: median mismatch, expected %0d, actual %0d", $time, want, got);
        errors++;
      end
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata  = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;

  median_scoreboard sb = new();
  bit  hold_request = 1'b0;
  int  idle_cycles  = 0;
  int  sent         = 0;
  int  send_mode    = 1;
  int  recv_mode    = 1;

  always #5 clk = ~clk;

  sliding_window_median_filter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  // mode 0: no idling, 1: full spread, 2: short gaps
  function automatic int pick_gap(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, MAX_GAP);
      default: return $urandom_range(0, 3);
    endcase
  endfunction

  task automatic send_sample(input sample_t v, input int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DW'($unsigned(v));
    do @(posedge clk); while (!s_tready);
    sb.note_sample(v);
    sent++;
  endtask

  // Drop valid so the last sample is not offered again, then wait out the medians.
  task automatic drain_medians();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Receiver: one stall per beat, plus one long hold-off on request.
  initial begin
    int stall;
    int received;
    received = 0;
    while (rst) @(posedge clk);
    forever begin
      if (received % 40 == 0) recv_mode = $urandom_range(0, 2);
      if (hold_request) begin
        stall        = HOLD_LEN;
        hold_request = 1'b0;
      end else begin
        stall = pick_gap(recv_mode);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_median(sample_t'(m_tdata[SB-1:0]));
      received++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
      $display("sliding_window_median_filter_test: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    sample_t directed [$];
    sample_t v;
    sample_t level;
    int      kind;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Start-up with zeros still in the ring, extremes, bit patterns, then ties.
    directed = '{16'sd5, -16'sd3, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                 16'sh8000, 16'sh8000, 16'sh5555, 16'shAAAA, -16'sd1, 16'sd1, 16'sd0,
                 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7, 16'sd7,
                 -16'sd7, 16'sd8};
    foreach (directed[i]) send_sample(directed[i], pick_gap(i < 12 ? 0 : 1));
    drain_medians();

    level = '0;
    kind  = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n % 30 == 0) begin
        kind      = $urandom_range(0, 3);
        send_mode = $urandom_range(0, 2);
      end
      if (n == 300) hold_request = 1'b1;
      if (n == 600) drain_medians();
      case (kind)
        0: v = sample_t'($urandom);
        1: v = sample_t'(int'($urandom_range(0, 8)) - 4);
        2: begin
          level = level + sample_t'(int'($urandom_range(0, 64)) - 32);
          v     = level + sample_t'(int'($urandom_range(0, 6)) - 3);
        end
        default: begin
          // steady level with occasional impulses the median should reject
          if ($urandom_range(0, 5) == 0) v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
          else                           v = level;
        end
      endcase
      send_sample(v, pick_gap(send_mode));
    end
    s_tvalid <= 1'b0;

    drain_medians();
    repeat (4 * (WIN + 2)) @(posedge clk);
    $display("covered %0d samples (%0d directed) and %0d medians, incl. start-up zeros,",
             sent, directed.size(), sb.checked);
    $display("ties, extremes, impulses, a %0d-cycle output stall and a full drain pause",
             HOLD_LEN);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("sliding_window_median_filter_test: done, clean");
    end else begin
      $display("sliding_window_median_filter_test: done, errors");
    end
    $finish;
  end

endmodule
